// File: design/nearest_node_access_check_assert.svh
// Assertion macros used by the checker file.
`ifndef NEAREST_NODE_ACCESS_CHECK_ASSERT_SVH
`define NEAREST_NODE_ACCESS_CHECK_ASSERT_SVH

// Implication in the same cycle.
`define NNAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle.
`define NNAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/nnac_pkg.sv
// ----------------------------------------------------------------------------
// nnac_pkg
// Types and constants shared by the nearest node access check block.
// ----------------------------------------------------------------------------
package nnac_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int COORD_W       = 16;  // Q8.8 point fields
  localparam int VEC_W         = 16;  // Q1.14 vector fields
  localparam int MD_W          = 17;
  localparam int CMA_W         = 16;
  localparam int CFG_DATA_W    = 17;
  localparam int CFG_IDX_W     = 1;
  localparam int DC_W          = 18;  // distance unit operand width
  localparam int DSQ_W         = 2 * DC_W;
  localparam int D2_W          = DSQ_W + 2;
  localparam int IDX_OUT_W     = 6;
  localparam int NODE_W        = 3 * COORD_W + 3 * VEC_W;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_MAX_ANGLE = 1'd1;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_ACCESS = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [COORD_W-1:0] point_z;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
    logic [COORD_W-1:0] target_z;
    logic [VEC_W-1:0]   vector_x;
    logic [VEC_W-1:0]   vector_y;
    logic [VEC_W-1:0]   vector_z;
  } item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] node_index;
    logic                 accessible;
    status_t              status;
  } result_t;

  // distance unit token kinds
  typedef enum logic [1:0] {
    TK_NODE = 2'd0,
    TK_FT   = 2'd1,
    TK_MD   = 2'd2
  } tkind_t;

  typedef struct packed {
    logic   valid;
    tkind_t kind;
  } dtag_t;

  typedef struct packed {
    logic   busy;
    logic   valid;
    tkind_t kind;
  } dstat_t;

  typedef logic [2:0][DC_W-1:0]  dvec_t;
  typedef logic [2:0][VEC_W-1:0] vvec_t;

  function automatic logic [DC_W-1:0] sx_coord(logic [COORD_W-1:0] v);
    return {{(DC_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

endpackage

// File: design/nnac_ram.sv
// ----------------------------------------------------------------------------
// nnac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nnac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/nnac_dist.sv
// ----------------------------------------------------------------------------
// nnac_dist
// Two-stage squared distance pipeline; one token per cycle, tag rides along.
// ----------------------------------------------------------------------------
module nnac_dist #(
  parameter int MAX_NODES = nnac_pkg::MAX_NODES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  nnac_pkg::dtag_t       in_tag,
  input  logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] in_idx,
  input  nnac_pkg::dvec_t       a,
  input  nnac_pkg::dvec_t       b,
  output nnac_pkg::dstat_t      stat,
  output logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] out_idx,
  output logic [nnac_pkg::D2_W-1:0] d2
);
  import nnac_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic signed [DC_W-1:0]  df [3];
  logic signed [DSQ_W-1:0] sq_c [3];
  logic [DSQ_W-1:0]        sq [3];
  dtag_t                   s1_tag;
  logic [IW-1:0]           s1_idx;
  dtag_t                   s2_tag;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      df[k]   = $signed(a[k]) - $signed(b[k]);
      sq_c[k] = df[k] * df[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
      s2_tag <= '0;
    end else begin
      s1_tag <= in_tag;
      s2_tag <= s1_tag;
    end
    s1_idx  <= in_idx;
    out_idx <= s1_idx;
    for (int k = 0; k < 3; k++) begin
      sq[k] <= sq_c[k];
    end
    d2 <= D2_W'(sq[0]) + D2_W'(sq[1]) + D2_W'(sq[2]);
  end

  assign stat.busy  = s1_tag.valid;
  assign stat.valid = s2_tag.valid;
  assign stat.kind  = s2_tag.kind;
endmodule

// File: design/nnac_angle.sv
// ----------------------------------------------------------------------------
// nnac_angle
// Angle test on one shared 33x33 multiplier stepped by a small sequencer.
// Compares |o.n|^2 * 2^28 against cos^2 * |o|^2 * |n|^2.
// ----------------------------------------------------------------------------
module nnac_angle (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  nnac_pkg::vvec_t      o,
  input  nnac_pkg::vvec_t      n,
  input  logic [nnac_pkg::CMA_W-1:0] c,
  output logic                 done,
  output logic                 ok
);
  import nnac_pkg::*;

  typedef enum logic [3:0] {
    S_DOT0, S_DOT1, S_DOT2, S_OO0, S_OO1, S_OO2, S_NN0, S_NN1, S_NN2,
    S_CC, S_P, S_AD, S_RLO, S_RHI
  } step_t;

  typedef enum logic [1:0] {A_IDLE, A_RUN, A_DRAIN, A_CMP} astate_t;

  astate_t            state;
  step_t              step;
  step_t              pstep;
  logic               pvalid;
  vvec_t              oreg;
  vvec_t              nreg;
  logic [CMA_W-1:0]   creg;
  logic signed [65:0] prod;
  logic signed [33:0] dot;
  logic [31:0]        no;
  logic [31:0]        nn;
  logic [30:0]        c2;
  logic [63:0]        p;
  logic [63:0]        ad2;
  logic [63:0]        rlo;
  logic [95:0]        r;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic [33:0]        dot_neg;
  logic [31:0]        ad;
  logic [95:0]        lhs;
  logic               dot_pos;
  logic               ge;
  logic               le;

  function automatic logic signed [32:0] sx16(logic [15:0] v);
    return {{17{v[15]}}, v};
  endfunction

  assign dot_neg = 34'(-dot);
  assign ad      = dot[33] ? dot_neg[31:0] : dot[31:0];
  assign lhs     = {4'b0, ad2, 28'b0};
  assign dot_pos = !dot[33];
  assign ge      = lhs >= r;
  assign le      = lhs <= r;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step)
      S_DOT0:  begin ma = sx16(oreg[2]); mb = sx16(nreg[2]); end
      S_DOT1:  begin ma = sx16(oreg[1]); mb = sx16(nreg[1]); end
      S_DOT2:  begin ma = sx16(oreg[0]); mb = sx16(nreg[0]); end
      S_OO0:   begin ma = sx16(oreg[2]); mb = sx16(oreg[2]); end
      S_OO1:   begin ma = sx16(oreg[1]); mb = sx16(oreg[1]); end
      S_OO2:   begin ma = sx16(oreg[0]); mb = sx16(oreg[0]); end
      S_NN0:   begin ma = sx16(nreg[2]); mb = sx16(nreg[2]); end
      S_NN1:   begin ma = sx16(nreg[1]); mb = sx16(nreg[1]); end
      S_NN2:   begin ma = sx16(nreg[0]); mb = sx16(nreg[0]); end
      S_CC:    begin ma = sx16(creg);    mb = sx16(creg);    end
      S_P:     begin ma = {1'b0, no};    mb = {1'b0, nn};    end
      S_AD:    begin ma = {1'b0, ad};    mb = {1'b0, ad};    end
      S_RLO:   begin ma = {2'b0, c2};    mb = {1'b0, p[31:0]};  end
      S_RHI:   begin ma = {2'b0, c2};    mb = {1'b0, p[63:32]}; end
      default: begin ma = '0;            mb = '0;            end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= A_IDLE;
      pvalid <= 1'b0;
      done   <= 1'b0;
      ok     <= 1'b0;
      step   <= S_DOT0;
    end else begin
      done   <= 1'b0;
      pvalid <= (state == A_RUN);
      unique case (state)
        A_IDLE: begin
          if (start) begin
            oreg  <= o;
            nreg  <= n;
            creg  <= c;
            step  <= S_DOT0;
            state <= A_RUN;
          end
        end
        A_RUN: begin
          if (step == S_RHI) begin
            state <= A_DRAIN;
          end else begin
            step <= step_t'(step + 4'd1);
          end
        end
        A_DRAIN: state <= A_CMP;
        A_CMP: begin
          done  <= 1'b1;
          state <= A_IDLE;
          if (no == '0 || nn == '0) begin
            ok <= 1'b0;
          end else if (!creg[CMA_W-1]) begin
            ok <= dot_pos && ge;
          end else begin
            ok <= dot_pos || le;
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  // product register and accumulation, keyed by the issued step held in pstep
  always_ff @(posedge clk) begin
    prod  <= ma * mb;
    pstep <= step;
    if (pvalid) begin
      case (pstep)
        S_DOT0:  dot <= 34'(prod);
        S_DOT1,
        S_DOT2:  dot <= dot + 34'(prod);
        S_OO0:   no  <= prod[31:0];
        S_OO1,
        S_OO2:   no  <= no + prod[31:0];
        S_NN0:   nn  <= prod[31:0];
        S_NN1,
        S_NN2:   nn  <= nn + prod[31:0];
        S_CC:    c2  <= prod[30:0];
        S_P:     p   <= prod[63:0];
        S_AD:    ad2 <= prod[63:0];
        S_RLO:   rlo <= prod[63:0];
        S_RHI:   r   <= {prod[63:0], 32'b0} + {32'b0, rlo};
        default: r   <= r;
      endcase
    end
  end
endmodule

// File: design/nearest_node_access_check.sv
// ----------------------------------------------------------------------------
// nearest_node_access_check
// Node table with linear nearest search and a normal/orientation angle test.
// Add and clear: result in the cycle after accept; a new item is taken only
// once the result has been taken. Find and access scan the table one node
// per cycle, and access then runs the 14-step multiplier unit on the best node.
// Reset empties the table and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module nearest_node_access_check #(
  parameter int MAX_NODES = nnac_pkg::MAX_NODES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  nnac_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output nnac_pkg::result_t                   result,
  input  logic                                cfg_write,
  input  logic [nnac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nnac_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import nnac_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef enum logic [2:0] {
    IDLE, SCAN, WAIT, NRD, ASTART, AWAIT, OUT
  } state_t;

  state_t             state;
  item_t              item_r;
  logic [CW-1:0]      count;
  logic [MD_W-1:0]    max_distance;
  logic [CMA_W-1:0]   cos_max_angle;
  logic [IW-1:0]      rd_addr;
  logic               rd_v;
  logic [IW-1:0]      rd_idx;
  logic [IW-1:0]      best;
  logic [D2_W-1:0]    best_d2;
  logic               have_best;
  logic [D2_W-1:0]    ft_d2;
  logic [D2_W-1:0]    md2;
  logic               accept;
  logic               ram_we;
  logic [IW-1:0]      ram_raddr;
  logic [NODE_W-1:0]  ram_wdata;
  logic [NODE_W-1:0]  ram_rdata;
  dtag_t              d_tag;
  dvec_t              d_a;
  dvec_t              d_b;
  dstat_t             d_stat;
  logic [IW-1:0]      d_idx;
  logic [D2_W-1:0]    d2;
  logic               ang_start;
  logic               ang_done;
  logic               ang_ok;
  vvec_t              ang_o;
  vvec_t              ang_n;

  assign item_stall = (state != IDLE);
  assign accept     = item_valid && !item_stall;
  assign ram_we     = accept && (item.mode == MODE_ADD) && (count < CW'(MAX_NODES));
  assign ram_wdata  = {item.point_x, item.point_y, item.point_z,
                       item.vector_x, item.vector_y, item.vector_z};
  assign ram_raddr  = (state == NRD) ? best : rd_addr;
  assign ang_start  = (state == ASTART);
  assign ang_o      = {item_r.vector_x, item_r.vector_y, item_r.vector_z};
  assign ang_n      = ram_rdata[3*VEC_W-1:0];

  nnac_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // distance unit feed: limit token on accept, the from-to token, then stored nodes
  always_comb begin
    d_tag = '0;
    d_a   = '0;
    d_b   = '0;
    if (rd_v) begin
      d_tag = '{valid: 1'b1, kind: TK_NODE};
      d_a   = {sx_coord(ram_rdata[NODE_W-1 -: COORD_W]),
               sx_coord(ram_rdata[NODE_W-1-COORD_W -: COORD_W]),
               sx_coord(ram_rdata[NODE_W-1-2*COORD_W -: COORD_W])};
      // access searches around the target, find around the point
      if (item_r.mode == MODE_ACCESS) begin
        d_b = {sx_coord(item_r.target_x), sx_coord(item_r.target_y),
               sx_coord(item_r.target_z)};
      end else begin
        d_b = {sx_coord(item_r.point_x), sx_coord(item_r.point_y),
               sx_coord(item_r.point_z)};
      end
    end else if (accept) begin
      d_tag = '{valid: 1'b1, kind: TK_MD};
      d_a   = {DC_W'(max_distance), {DC_W{1'b0}}, {DC_W{1'b0}}};
    end else if (state == SCAN && rd_addr == '0) begin
      d_tag = '{valid: 1'b1, kind: TK_FT};
      d_a   = {sx_coord(item_r.target_x), sx_coord(item_r.target_y),
               sx_coord(item_r.target_z)};
      d_b   = {sx_coord(item_r.point_x), sx_coord(item_r.point_y),
               sx_coord(item_r.point_z)};
    end
  end

  nnac_dist #(.MAX_NODES(MAX_NODES)) u_dist (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (d_tag),
    .in_idx  (rd_idx),
    .a       (d_a),
    .b       (d_b),
    .stat    (d_stat),
    .out_idx (d_idx),
    .d2      (d2)
  );

  nnac_angle u_angle (
    .clk   (clk),
    .rst   (rst),
    .start (ang_start),
    .o     (ang_o),
    .n     (ang_n),
    .c     (cos_max_angle),
    .done  (ang_done),
    .ok    (ang_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      count         <= '0;
      max_distance  <= {MD_W{1'b1}};
      cos_max_angle <= 16'hC000;
      result_valid  <= 1'b0;
      rd_v          <= 1'b0;
      have_best     <= 1'b0;
      rd_addr       <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MAX_DISTANCE:  max_distance  <= cfg_data[MD_W-1:0];
          REG_COS_MAX_ANGLE: cos_max_angle <= cfg_data[CMA_W-1:0];
          default: ;
        endcase
      end

      rd_v   <= (state == SCAN);
      rd_idx <= rd_addr;

      if (d_stat.valid) begin
        case (d_stat.kind)
          TK_NODE: begin
            if (!have_best || d2 < best_d2) begin
              best      <= d_idx;
              best_d2   <= d2;
              have_best <= 1'b1;
            end
          end
          TK_FT:   ft_d2 <= d2;
          TK_MD:   md2   <= d2;
          default: ;
        endcase
      end

      unique case (state)
        IDLE: begin
          if (accept) begin
            item_r    <= item;
            have_best <= 1'b0;
            rd_addr   <= '0;
            unique case (item.mode)
              MODE_ADD: begin
                if (count < CW'(MAX_NODES)) begin
                  result <= '{node_index: IDX_OUT_W'(count[IW-1:0]),
                              accessible: 1'b0, status: ST_OK};
                  count  <= count + CW'(1);
                end else begin
                  result <= '{node_index: '0, accessible: 1'b0, status: ST_FULL};
                end
                result_valid <= 1'b1;
                state        <= OUT;
              end
              MODE_CLEAR: begin
                count        <= '0;
                result       <= '{node_index: '0, accessible: 1'b0, status: ST_OK};
                result_valid <= 1'b1;
                state        <= OUT;
              end
              MODE_FIND, MODE_ACCESS: begin
                if (count == '0) begin
                  result       <= '{node_index: '0, accessible: 1'b0, status: ST_EMPTY};
                  result_valid <= 1'b1;
                  state        <= OUT;
                end else begin
                  state <= SCAN;
                end
              end
              default: state <= IDLE;
            endcase
          end
        end
        SCAN: begin
          rd_addr <= rd_addr + IW'(1);
          if (CW'(rd_addr) + CW'(1) == count) begin
            state <= WAIT;
          end
        end
        WAIT: begin
          // pipeline drained: best is final
          if (!rd_v && !d_stat.busy && !d_stat.valid) begin
            if (item_r.mode == MODE_FIND) begin
              result       <= '{node_index: IDX_OUT_W'(best), accessible: 1'b0,
                                status: ST_OK};
              result_valid <= 1'b1;
              state        <= OUT;
            end else begin
              state <= NRD;
            end
          end
        end
        NRD:    state <= ASTART;
        ASTART: state <= AWAIT;
        AWAIT: begin
          if (ang_done) begin
            result       <= '{node_index: IDX_OUT_W'(best),
                              accessible: ang_ok && (ft_d2 <= md2), status: ST_OK};
            result_valid <= 1'b1;
            state        <= OUT;
          end
        end
        OUT: begin
          if (!result_stall) begin
            result_valid <= 1'b0;
            state        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// File: design/nnac_checker.sv
// ----------------------------------------------------------------------------
// nnac_checker
// Port-level checks on the nearest node access check block, bound to the top.
// ----------------------------------------------------------------------------
`include "nearest_node_access_check_assert.svh"

module nnac_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input nnac_pkg::result_t result
);
  import nnac_pkg::*;

  `NNAC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "result changed while stalled")
  `NNAC_ASSERT_NOW(a_busy_on_result, result_valid, item_stall, "new transaction taken while result pending")
  `NNAC_ASSERT_NOW(a_fail_not_access, result_valid && result.status != ST_OK, !result.accessible, "accessible set with non-ok status")
  `NNAC_ASSERT_NOW(a_empty_index, result_valid && result.status == ST_EMPTY, result.node_index == '0, "nonzero index on empty table")
endmodule

bind nearest_node_access_check nnac_checker u_nnac_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nearest_node_access_check. A driver pulls queued
// transactions onto the item port, an internal node-table model predicts each
// result on accept, and a monitor compares results field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import nnac_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  item_t                 item;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  nearest_node_access_check DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int TABLE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 600;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  item_t   send_q[$];
  result_t expected_q[$];
  item_t   gen_nodes[$];
  int      errors = 0;
  int      cycle = 0;
  bit      quiet;
  bit      hold_req = 0;
  bit      hold_done = 0;
  int      hold_left = 0;

  // node table model
  longint  tbl_pos[TABLE_DEPTH][3];
  longint  tbl_nrm[TABLE_DEPTH][3];
  int      tbl_count;
  longint  max_dist;
  longint  cos_limit;

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint sq_dist(longint ax, longint ay, longint az,
                                     longint bx, longint by, longint bz);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by) + (az - bz) * (az - bz);
  endfunction

  function automatic int nearest_node(longint x, longint y, longint z);
    int best;
    longint bd;
    longint d;
    best = 0;
    bd = 0;
    for (int i = 0; i < tbl_count; i++) begin
      d = sq_dist(tbl_pos[i][0], tbl_pos[i][1], tbl_pos[i][2], x, y, z);
      if (i == 0 || d < bd) begin
        bd = d;
        best = i;
      end
    end
    return best;
  endfunction

  // exact angle test: 2^28 * dot^2 against cos^2 * |o|^2 * |n|^2
  function automatic bit angle_within(longint ox, longint oy, longint oz, int k);
    longint      dot;
    longint      no;
    longint      nn;
    longint      ad;
    logic [127:0] lhs;
    logic [127:0] rhs;
    dot = ox * tbl_nrm[k][0] + oy * tbl_nrm[k][1] + oz * tbl_nrm[k][2];
    no  = ox * ox + oy * oy + oz * oz;
    nn  = tbl_nrm[k][0] * tbl_nrm[k][0] + tbl_nrm[k][1] * tbl_nrm[k][1]
        + tbl_nrm[k][2] * tbl_nrm[k][2];
    if (no == 0 || nn == 0) return 1'b0;
    ad  = (dot < 0) ? -dot : dot;
    lhs = (128'(ad) * 128'(ad)) << 28;
    rhs = 128'(cos_limit * cos_limit) * 128'(no * nn);
    if (cos_limit >= 0) return (dot >= 0) && (lhs >= rhs);
    return (dot >= 0) || (lhs <= rhs);
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    longint  p[3];
    longint  t[3];
    longint  v[3];
    int      k;
    r = '0;
    r.status = ST_OK;
    p[0] = sx16(it.point_x);  p[1] = sx16(it.point_y);  p[2] = sx16(it.point_z);
    t[0] = sx16(it.target_x); t[1] = sx16(it.target_y); t[2] = sx16(it.target_z);
    v[0] = sx16(it.vector_x); v[1] = sx16(it.vector_y); v[2] = sx16(it.vector_z);
    case (it.mode)
      MODE_ADD: begin
        if (tbl_count < TABLE_DEPTH) begin
          for (int a = 0; a < 3; a++) begin
            tbl_pos[tbl_count][a] = p[a];
            tbl_nrm[tbl_count][a] = v[a];
          end
          r.node_index = IDX_OUT_W'(tbl_count);
          tbl_count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      MODE_CLEAR: tbl_count = 0;
      MODE_FIND: begin
        if (tbl_count == 0) r.status = ST_EMPTY;
        else r.node_index = IDX_OUT_W'(nearest_node(p[0], p[1], p[2]));
      end
      default: begin
        if (tbl_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          k = nearest_node(t[0], t[1], t[2]);
          r.node_index = IDX_OUT_W'(k);
          if (sq_dist(t[0], t[1], t[2], p[0], p[1], p[2]) <= max_dist * max_dist &&
              angle_within(v[0], v[1], v[2], k))
            r.accessible = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("** nearest_node_access_check: FAILED **");
      $finish;
    end
  end

  assign quiet = (cycle >= 30000 && cycle < 36000);

  // item driver
  always @(posedge clk) begin : drive_items
    bit busy;
    if (rst) begin
      item_valid <= 1'b0;
      item       <= '0;
    end else begin
      busy = item_valid;
      if (item_valid && !item_stall) begin
        expected_q = {expected_q, predict_result(item)};
        void'(send_q.pop_front());
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_q.size() > 0 && (quiet || $urandom_range(99) >= 33)) begin
          item_valid <= 1'b1;
          item       <= send_q[0];
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result stall, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      result_stall <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      result_stall <= !quiet && ($urandom_range(99) < 33);
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction, node_index", result.node_index, 0);
      end else begin
        want = expected_q.pop_front();
        if (result.node_index !== want.node_index)
          report_mismatch("node_index", result.node_index, want.node_index);
        if (result.accessible !== want.accessible)
          report_mismatch("accessible", result.accessible, want.accessible);
        if (result.status !== want.status)
          report_mismatch("status", result.status, want.status);
      end
    end
  end

  task automatic wait_idle();
    wait (send_q.size() == 0 && expected_q.size() == 0 && !item_valid);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_MAX_DISTANCE) max_dist = longint'(val);
    else cos_limit = sx16(val[15:0]);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_limits(int md, int cma);
    write_reg(REG_MAX_DISTANCE, CFG_DATA_W'(md));
    write_reg(REG_COS_MAX_ANGLE, {1'b0, 16'(cma)});
  endtask

  function automatic item_t mk(mode_t m, int px, int py, int pz, int tx, int ty,
                               int tz, int vx, int vy, int vz);
    item_t it;
    it.mode = m;
    it.point_x = 16'(px);  it.point_y = 16'(py);  it.point_z = 16'(pz);
    it.target_x = 16'(tx); it.target_y = 16'(ty); it.target_z = 16'(tz);
    it.vector_x = 16'(vx); it.vector_y = 16'(vy); it.vector_z = 16'(vz);
    return it;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(5))
      0, 1: return $urandom_range(16) - 8;  // cluster, forces ties
      2:    return ($urandom_range(1)) ? 32767 : -32768;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic int rand_vec();
    case ($urandom_range(5))
      0: return 0;
      1: return ($urandom_range(1)) ? 16384 : -16384;
      default: return $urandom_range(32768) - 16384;
    endcase
  endfunction

  function automatic int clamp_vec(int v);
    return (v > 16384) ? 16384 : (v < -16384) ? -16384 : v;
  endfunction

  // append one transaction to the send queue
  task automatic enqueue(item_t it);
    send_q = {send_q, it};
  endtask

  task automatic push_node();
    item_t it;
    it = mk(MODE_ADD, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), rand_coord(), rand_vec(), rand_vec(), rand_vec());
    enqueue(it);
    if (gen_nodes.size() < TABLE_DEPTH) gen_nodes = {gen_nodes, it};
  endtask

  task automatic push_query();
    item_t it;
    item_t nd;
    int    tx, ty, tz, span;
    it = mk(mode_t'($urandom_range(2, 3)), rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), rand_coord(), rand_coord(), rand_vec(), rand_vec(), rand_vec());
    if (gen_nodes.size() > 0 && $urandom_range(3) != 0) begin
      nd = gen_nodes[$urandom_range(gen_nodes.size() - 1)];
      tx = int'($signed(nd.point_x)) + $urandom_range(6) - 3;
      ty = int'($signed(nd.point_y)) + $urandom_range(6) - 3;
      tz = int'($signed(nd.point_z)) + $urandom_range(6) - 3;
      span = int'(max_dist) / 2 + 2;
      it.target_x = 16'(tx); it.target_y = 16'(ty); it.target_z = 16'(tz);
      it.point_x = 16'(tx + $urandom_range(span) - span / 2);
      it.point_y = 16'(ty + $urandom_range(span) - span / 2);
      it.point_z = 16'(tz + $urandom_range(span) - span / 2);
      if (it.mode == MODE_FIND) begin
        it.point_x = it.target_x; it.point_y = it.target_y; it.point_z = it.target_z;
      end
      if ($urandom_range(1)) begin
        it.vector_x = 16'(clamp_vec(int'($signed(nd.vector_x)) + $urandom_range(800) - 400));
        it.vector_y = 16'(clamp_vec(int'($signed(nd.vector_y)) + $urandom_range(800) - 400));
        it.vector_z = 16'(clamp_vec(int'($signed(nd.vector_z)) + $urandom_range(800) - 400));
      end
    end
    enqueue(it);
  endtask

  task automatic run_phase(int n_items);
    int sent;
    int n;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) begin
        enqueue(mk(MODE_CLEAR, rand_coord(), 0, 0, 0, 0, 0, rand_vec(), 0, 0));
        gen_nodes.delete();
        sent++;
      end
      n = ($urandom_range(7) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 12);
      for (int i = 0; i < n; i++) push_node();
      sent += n;
      n = $urandom_range(3, 10);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0)
          enqueue(mk(mode_t'($urandom_range(3)), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_vec(), rand_vec(), rand_vec()));
        else
          push_query();
      end
      sent += n;
      wait (send_q.size() < 8);
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    tbl_count = 0;
    max_dist  = 131071;
    cos_limit = -16384;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, ties, zero vectors
    enqueue(mk(MODE_FIND, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    enqueue(mk(MODE_ACCESS, -32768, -32768, -32768, 32767, 32767, 32767,
               16384, 0, 0));
    enqueue(mk(MODE_ADD, -32768, -32768, -32768, 0, 0, 0, -16384, 0, 0));
    enqueue(mk(MODE_ADD, 32767, 32767, 32767, 0, 0, 0, 16384, 16384, 16384));
    enqueue(mk(MODE_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    enqueue(mk(MODE_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 16384));
    enqueue(mk(MODE_FIND, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    enqueue(mk(MODE_FIND, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0));
    enqueue(mk(MODE_FIND, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0));
    enqueue(mk(MODE_ACCESS, -32768, -32768, -32768, 32767, 32767, 32767,
               16384, 16384, 16384));
    enqueue(mk(MODE_ACCESS, 5, 5, 5, 1, 1, 1, 0, 16384, 0));
    enqueue(mk(MODE_ACCESS, 0, 0, 0, 32767, 32767, 32767, 0, 0, 0));
    enqueue(mk(MODE_ACCESS, 0, 0, 0, 32767, 32767, 32767,
               -16384, -16384, -16384));
    wait_idle();
    set_limits(0, 16384);
    enqueue(mk(MODE_ACCESS, 1, 0, 0, 32767, 32767, 32767, 16384, 16384, 16384));
    enqueue(mk(MODE_ACCESS, 32767, 32767, 32767, 32767, 32767, 32767,
               16384, 16384, 16384));
    enqueue(mk(MODE_ACCESS, 32767, 32767, 32767, 32767, 32767, 32767,
               16384, 16384, 16383));
    enqueue(mk(MODE_ACCESS, -32768, -32768, -32768, -32768, -32768, -32768,
               -16384, 0, 0));
    enqueue(mk(MODE_CLEAR, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    enqueue(mk(MODE_FIND, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    enqueue(mk(MODE_ACCESS, 0, 0, 0, 0, 0, 0, 16384, 0, 0));
    wait_idle();

    // random phases over several register settings
    hold_req = 1'b1;
    gen_nodes.delete();
    set_limits(131071, -16384); run_phase(220); wait_idle();
    set_limits(0, 16384);       run_phase(220); wait_idle();
    set_limits($urandom_range(131071), $urandom_range(32768) - 16384);
    run_phase(220); wait_idle();
    set_limits(131071, 0);      run_phase(220); wait_idle();
    set_limits($urandom_range(40000), -$urandom_range(16384));
    run_phase(220); wait_idle();
    set_limits($urandom_range(131071), $urandom_range(11585, 16384));
    run_phase(220);

    wait (send_q.size() == 0 && expected_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("** nearest_node_access_check: PASSED **");
    end else begin
      $display("** nearest_node_access_check: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/nnac_pkg.sv
design/nnac_ram.sv
design/nnac_dist.sv
design/nnac_angle.sv
design/nearest_node_access_check.sv
design/nnac_checker.sv
tb/tb.sv
